[rtl/rrsi_pkg.sv]
// Shared types and codes for the ray versus rectangle slab intersection block.
`timescale 1ns / 1ps
`default_nettype none
package rrsi_pkg;

  // Contact normal codes reported on a hit.
  typedef enum logic [2:0] {
    NORMAL_NONE    = 3'd0,
    NORMAL_PLUS_X  = 3'd1,
    NORMAL_MINUS_X = 3'd2,
    NORMAL_PLUS_Y  = 3'd3,
    NORMAL_MINUS_Y = 3'd4
  } normal_code_t;

  // Occupancy status of the queue between the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage
`default_nettype wire

[rtl/rrsi_front.sv]
// Front part: takes a query beat and forms the four slab edge numerators.
`timescale 1ns / 1ps
`default_nettype none
module rrsi_front #(
  parameter int CW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic signed [CW-1:0] origin_x,
  input  logic signed [CW-1:0] origin_y,
  input  logic signed [CW-1:0] dir_x,
  input  logic signed [CW-1:0] dir_y,
  input  logic signed [CW-1:0] rect_left,
  input  logic signed [CW-1:0] rect_top,
  input  logic        [CW-2:0] rect_width,
  input  logic        [CW-2:0] rect_height,
  output logic                 rec_valid,
  output logic [4*(CW+2)+4*CW-1:0] rec
);
  localparam int NB = CW + 2;

  logic signed [NB-1:0] ox_e, oy_e, rl_e, rt_e, rw_e, rh_e;
  logic signed [NB-1:0] n_lx, n_rx, n_ty, n_by;

  assign ox_e = NB'(origin_x);
  assign oy_e = NB'(origin_y);
  assign rl_e = NB'(rect_left);
  assign rt_e = NB'(rect_top);
  assign rw_e = $signed(NB'(rect_width));
  assign rh_e = $signed(NB'(rect_height));

  assign n_lx = rl_e - ox_e;
  assign n_rx = rl_e + rw_e - ox_e;
  assign n_ty = rt_e - oy_e;
  assign n_by = rt_e + rh_e - oy_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else begin
      rec_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rec <= {n_lx, n_rx, n_ty, n_by, origin_x, origin_y, dir_x, dir_y};
    end
  end
endmodule
`default_nettype wire

[rtl/rrsi_queue.sv]
// Two-entry queue that decouples the front part from the back part.
`timescale 1ns / 1ps
`default_nettype none
module rrsi_queue #(
  parameter int W = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [W-1:0]           push_data,
  input  logic                   pop,
  output logic [W-1:0]           head,
  output rrsi_pkg::queue_status_t status
);
  logic [W-1:0] slot [0:1];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   count;
  logic         do_push, do_pop;

  assign do_push = push && (count != 2'd2);
  assign do_pop  = pop && (count != 2'd0);
  assign head    = slot[rd_ptr];
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= push_data;
  end
endmodule
`default_nettype wire

[rtl/rrsi_div.sv]
// Pipelined fixed-point divider lane with saturation and zero-over-zero flag.
`timescale 1ns / 1ps
`default_nettype none
module rrsi_div #(
  parameter int CW = 32,
  parameter int F  = 16
) (
  input  logic                 clk,
  input  logic signed [CW+1:0] n,
  input  logic signed [CW-1:0] d,
  output logic signed [CW-1:0] q,
  output logic                 nan
);
  localparam int NB = CW + 2;
  localparam int RW = 2 * CW + F;
  localparam int NS = CW - 1;
  localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  // Input stage: magnitudes and special cases.
  logic [NB-1:0] un0;
  logic [CW-1:0] ud0;
  logic          neg0, dz0, nz0, nneg0;

  always_ff @(posedge clk) begin
    un0   <= n[NB-1] ? NB'(-n) : NB'(n);
    ud0   <= d[CW-1] ? CW'(-d) : CW'(d);
    neg0  <= n[NB-1] ^ d[CW-1];
    dz0   <= (d == '0);
    nz0   <= (n == '0);
    nneg0 <= n[NB-1];
  end

  logic [RW-1:0] rem_s [0:NS-1];
  logic [CW-1:0] ud_s  [0:NS-1];
  logic [CW-2:0] q_s   [0:NS];
  logic          sat_s [0:NS];
  logic          neg_s [0:NS];
  logic          nan_s [0:NS];

  logic [RW-1:0] num1, lim1;
  assign num1 = RW'(un0) << F;
  assign lim1 = RW'(ud0) << (CW - 1);

  // Overflow stage: a quotient at or above the sign bit saturates.
  always_ff @(posedge clk) begin
    rem_s[0] <= num1;
    ud_s[0]  <= ud0;
    q_s[0]   <= '0;
    sat_s[0] <= dz0 ? 1'b1 : (num1 >= lim1);
    neg_s[0] <= dz0 ? nneg0 : neg0;
    nan_s[0] <= dz0 && nz0;
  end

  // One quotient bit per stage, most significant first.
  for (genvar j = 0; j < NS; j++) begin : g_bit
    localparam int SH = NS - 1 - j;
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = RW'(ud_s[j]) << SH;
    assign ge  = (rem_s[j] >= dsh);

    always_ff @(posedge clk) begin
      q_s[j+1]   <= q_s[j] | ((CW-1)'(ge) << SH);
      sat_s[j+1] <= sat_s[j];
      neg_s[j+1] <= neg_s[j];
      nan_s[j+1] <= nan_s[j];
    end

    if (j < NS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_s[j+1] <= ge ? (rem_s[j] - dsh) : rem_s[j];
        ud_s[j+1]  <= ud_s[j];
      end
    end
  end

  logic [CW-1:0] qe;
  assign qe = {1'b0, q_s[NS]};

  always_ff @(posedge clk) begin
    nan <= nan_s[NS];
    if (nan_s[NS]) begin
      q <= '0;
    end else if (sat_s[NS]) begin
      q <= neg_s[NS] ? CMIN : CMAX;
    end else begin
      q <= neg_s[NS] ? CW'(~qe + CW'(1)) : qe;
    end
  end
endmodule
`default_nettype wire

[rtl/rrsi_back.sv]
// Back part: slab divisions, interval ordering, hit test and point evaluation.
`timescale 1ns / 1ps
`default_nettype none
module rrsi_back #(
  parameter int CW = 32,
  parameter int F  = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [4*(CW+2)+4*CW-1:0]   rec,
  output logic                       out_valid,
  output logic                       line_crosses,
  output logic                       hit,
  output logic [2:0]                 normal_code,
  output logic signed [CW-1:0]       near_time,
  output logic signed [CW-1:0]       near_x,
  output logic signed [CW-1:0]       near_y,
  output logic signed [CW-1:0]       far_x,
  output logic signed [CW-1:0]       far_y
);
  localparam int NB  = CW + 2;
  localparam int LAT = CW + 2;
  localparam int PW  = 2 * CW;
  localparam int SW  = 2 * CW + 1;
  localparam logic signed [CW-1:0] ONE_T = CW'(1) << F;
  localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  logic signed [NB-1:0] n_lx, n_rx, n_ty, n_by;
  logic signed [CW-1:0] ox_i, oy_i, dx_i, dy_i;
  assign {n_lx, n_rx, n_ty, n_by, ox_i, oy_i, dx_i, dy_i} = rec;

  logic signed [CW-1:0] t_lx, t_rx, t_ty, t_by;
  logic                 nan_lx, nan_rx, nan_ty, nan_by;

  rrsi_div #(.CW(CW), .F(F)) u_div_lx (.clk, .n(n_lx), .d(dx_i), .q(t_lx), .nan(nan_lx));
  rrsi_div #(.CW(CW), .F(F)) u_div_rx (.clk, .n(n_rx), .d(dx_i), .q(t_rx), .nan(nan_rx));
  rrsi_div #(.CW(CW), .F(F)) u_div_ty (.clk, .n(n_ty), .d(dy_i), .q(t_ty), .nan(nan_ty));
  rrsi_div #(.CW(CW), .F(F)) u_div_by (.clk, .n(n_by), .d(dy_i), .q(t_by), .nan(nan_by));

  // Side data travels beside the dividers.
  logic          vld_d [0:LAT-1];
  logic [CW-1:0] ox_d [0:LAT-1];
  logic [CW-1:0] oy_d [0:LAT-1];
  logic [CW-1:0] dx_d [0:LAT-1];
  logic [CW-1:0] dy_d [0:LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld_d[i] <= 1'b0;
    end else begin
      vld_d[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld_d[i] <= vld_d[i-1];
    end
  end

  always_ff @(posedge clk) begin
    ox_d[0] <= ox_i;
    oy_d[0] <= oy_i;
    dx_d[0] <= dx_i;
    dy_d[0] <= dy_i;
    for (int i = 1; i < LAT; i++) begin
      ox_d[i] <= ox_d[i-1];
      oy_d[i] <= oy_d[i-1];
      dx_d[i] <= dx_d[i-1];
      dy_d[i] <= dy_d[i-1];
    end
  end

  // Stage A: order the slab times and test the interval overlap.
  logic signed [CW-1:0] nx, fx, ny, fy, tn_c, tf_c;
  logic                 cross_c, hit_c;
  logic [2:0]           code_c;

  always_comb begin
    nx = (t_lx > t_rx) ? t_rx : t_lx;
    fx = (t_lx > t_rx) ? t_lx : t_rx;
    ny = (t_ty > t_by) ? t_by : t_ty;
    fy = (t_ty > t_by) ? t_ty : t_by;
    tn_c = (nx > ny) ? nx : ny;
    tf_c = (fx < fy) ? fx : fy;
    cross_c = !(nan_lx || nan_rx || nan_ty || nan_by) && (nx < fy) && (ny < fx);
    hit_c = cross_c && (tf_c >= 0) && (tn_c <= ONE_T);
    code_c = rrsi_pkg::NORMAL_NONE;
    if (hit_c) begin
      priority if (nx > ny) begin
        code_c = dx_d[LAT-1][CW-1] ? rrsi_pkg::NORMAL_PLUS_X : rrsi_pkg::NORMAL_MINUS_X;
      end else if (nx < ny) begin
        code_c = dy_d[LAT-1][CW-1] ? rrsi_pkg::NORMAL_PLUS_Y : rrsi_pkg::NORMAL_MINUS_Y;
      end else begin
        // Equal entry times on both axes: a corner contact has no single normal.
        code_c = rrsi_pkg::NORMAL_NONE;
      end
    end
  end

  logic                 vld_a, cross_a, hit_a;
  logic [2:0]           code_a;
  logic signed [CW-1:0] tn_a, tf_a, ox_a, oy_a, dx_a, dy_a;

  always_ff @(posedge clk) begin
    if (rst) vld_a <= 1'b0;
    else     vld_a <= vld_d[LAT-1];
  end

  always_ff @(posedge clk) begin
    cross_a <= cross_c;
    hit_a   <= hit_c;
    code_a  <= code_c;
    tn_a    <= tn_c;
    tf_a    <= tf_c;
    ox_a    <= ox_d[LAT-1];
    oy_a    <= oy_d[LAT-1];
    dx_a    <= dx_d[LAT-1];
    dy_a    <= dy_d[LAT-1];
  end

  // Stage B: four magnitude products.
  function automatic logic [CW-1:0] mag(input logic [CW-1:0] v);
    return v[CW-1] ? CW'(~v + CW'(1)) : v;
  endfunction

  logic                 vld_b, cross_b, hit_b;
  logic [2:0]           code_b;
  logic signed [CW-1:0] tn_b, ox_b, oy_b;
  logic [PW-1:0]        p_nx, p_ny, p_fx, p_fy;
  logic                 s_nx, s_ny, s_fx, s_fy;

  always_ff @(posedge clk) begin
    if (rst) vld_b <= 1'b0;
    else     vld_b <= vld_a;
  end

  always_ff @(posedge clk) begin
    cross_b <= cross_a;
    hit_b   <= hit_a;
    code_b  <= code_a;
    tn_b    <= tn_a;
    ox_b    <= ox_a;
    oy_b    <= oy_a;
    p_nx    <= PW'(mag(dx_a)) * PW'(mag(tn_a));
    p_ny    <= PW'(mag(dy_a)) * PW'(mag(tn_a));
    p_fx    <= PW'(mag(dx_a)) * PW'(mag(tf_a));
    p_fy    <= PW'(mag(dy_a)) * PW'(mag(tf_a));
    s_nx    <= dx_a[CW-1] ^ tn_a[CW-1];
    s_ny    <= dy_a[CW-1] ^ tn_a[CW-1];
    s_fx    <= dx_a[CW-1] ^ tf_a[CW-1];
    s_fy    <= dy_a[CW-1] ^ tf_a[CW-1];
  end

  // Stage C: drop the fraction, add the origin and saturate.
  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] o,
                                            input logic [PW-1:0] p,
                                            input logic neg);
    logic signed [SW-1:0] oe, pe, sum;
    oe = SW'($signed(o));
    pe = $signed(SW'(p >> F));
    sum = neg ? (oe - pe) : (oe + pe);
    if (sum > $signed(SW'(CMAX))) return CMAX;
    if (sum < $signed({{(CW+1){1'b1}}, CMIN})) return CMIN;
    return sum[CW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= vld_b;
  end

  always_ff @(posedge clk) begin
    line_crosses <= cross_b;
    hit          <= hit_b;
    normal_code  <= code_b;
    near_time    <= cross_b ? tn_b : '0;
    near_x       <= cross_b ? sat_add(ox_b, p_nx, s_nx) : '0;
    near_y       <= cross_b ? sat_add(oy_b, p_ny, s_ny) : '0;
    far_x        <= cross_b ? sat_add(ox_b, p_fx, s_fx) : '0;
    far_y        <= cross_b ? sat_add(oy_b, p_fy, s_fy) : '0;
  end
endmodule
`default_nettype wire

[rtl/ray_rectangle_slab_intersect.sv]
// Top level of the 2D ray segment versus axis-aligned rectangle intersection block.
`timescale 1ns / 1ps
`default_nettype none
// A query beat is taken at any rising edge where start is high and busy is low,
// and one beat may follow in every cycle. Each query yields exactly one result
// beat, shown for one cycle with done high, in query order. The receiver cannot
// hold results off, so the block never stalls on its output side. A query
// passes a numerator stage in front, the decoupling queue, the four pipelined
// slab dividers, which take COORD_WIDTH + 2 stages and resolve one quotient bit
// in each of their bit stages, the interval ordering stage, one multiplier stage
// and a final saturating add stage. The queue between the front and back parts
// drains every cycle, so busy stays low in operation.
// All coordinates and times are signed fixed point with FRAC_BITS fraction bits;
// zero divided by zero on any slab edge reports no crossing, with all outputs zero.
module ray_rectangle_slab_intersect #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] origin_x,
  input  logic signed [COORD_WIDTH-1:0] origin_y,
  input  logic signed [COORD_WIDTH-1:0] dir_x,
  input  logic signed [COORD_WIDTH-1:0] dir_y,
  input  logic signed [COORD_WIDTH-1:0] rect_left,
  input  logic signed [COORD_WIDTH-1:0] rect_top,
  input  logic        [COORD_WIDTH-2:0] rect_width,
  input  logic        [COORD_WIDTH-2:0] rect_height,
  output logic                          done,
  output logic                          line_crosses,
  output logic                          hit,
  output logic [2:0]                    normal_code,
  output logic signed [COORD_WIDTH-1:0] near_time,
  output logic signed [COORD_WIDTH-1:0] near_x,
  output logic signed [COORD_WIDTH-1:0] near_y,
  output logic signed [COORD_WIDTH-1:0] far_x,
  output logic signed [COORD_WIDTH-1:0] far_y
);
  localparam int CW = COORD_WIDTH;
  localparam int RECW = 4 * (CW + 2) + 4 * CW;

  rrsi_pkg::queue_status_t q_status;
  logic            take, rec_valid, back_valid;
  logic [RECW-1:0] rec, head;

  // The front accepts a beat only while the queue has room.
  assign busy = q_status.full;
  assign take = start && !busy;
  assign back_valid = !q_status.empty;

  rrsi_front #(.CW(CW)) u_front (
    .clk, .rst, .take,
    .origin_x, .origin_y, .dir_x, .dir_y,
    .rect_left, .rect_top, .rect_width, .rect_height,
    .rec_valid, .rec
  );

  // The back part never stalls, so it pops the head whenever one is present.
  rrsi_queue #(.W(RECW)) u_queue (
    .clk, .rst,
    .push(rec_valid), .push_data(rec),
    .pop(back_valid), .head,
    .status(q_status)
  );

  rrsi_back #(.CW(CW), .F(FRAC_BITS)) u_back (
    .clk, .rst,
    .in_valid(back_valid), .rec(head),
    .out_valid(done),
    .line_crosses, .hit, .normal_code, .near_time,
    .near_x, .near_y, .far_x, .far_y
  );

  // A hit is only possible on a line that crosses the rectangle.
  assert property (@(posedge clk) disable iff (rst) done && hit |-> line_crosses)
    else $error("hit reported without a crossing");

  // Without a crossing every numeric output is zero.
  assert property (@(posedge clk) disable iff (rst)
    done && !line_crosses |-> near_time == '0 && near_x == '0 && near_y == '0 &&
                              far_x == '0 && far_y == '0)
    else $error("nonzero outputs without a crossing");

  // A contact normal is reported only on a hit.
  assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> normal_code == rrsi_pkg::NORMAL_NONE)
    else $error("normal code without a hit");

  // The front never pushes into a full queue.
  assert property (@(posedge clk) disable iff (rst) rec_valid |-> !q_status.full)
    else $error("queue overflow");
endmodule
`default_nettype wire
